/* sv/crsf_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the crc-8 helper for the crsf frame receiver
// no dependencies; imported by crsf_ctrl, crsf_dp and crsf_frame_receiver
package crsf_pkg;

    localparam int MAX_FRAME = 64;
    localparam int FILL_W    = $clog2(MAX_FRAME + 1);

    localparam logic [7:0] SYNC_BYTE        = 8'hC8;
    localparam logic [7:0] TYPE_LINK_STATS  = 8'h14;
    localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
    localparam logic [7:0] CRC_POLY         = 8'hD5;
    localparam logic [7:0] MIN_LEN          = 8'd2;
    localparam logic [7:0] MAX_LEN          = 8'(MAX_FRAME - 2);
    localparam logic [7:0] RC_FRAME_LEN     = 8'd26;
    localparam logic [7:0] LINK_MIN_LEN     = 8'd12;

    // rc payload sits at frame bytes 3 .. 24: sixteen 11-bit channels
    localparam int NUM_CHANNELS  = 16;
    localparam int CHAN_W        = 11;
    localparam int CHAN_IDX_W    = $clog2(NUM_CHANNELS);
    localparam int RC_FIRST_BYTE = 3;
    localparam int RC_LAST_BYTE  = 24;
    localparam int RC_BITS       = NUM_CHANNELS * CHAN_W;
    localparam int LINK_FIRST    = 3;

    typedef enum logic [1:0] {
        KIND_BAD_CRC = 2'd0,
        KIND_CHANNEL = 2'd1,
        KIND_LINK    = 2'd2,
        KIND_OTHER   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_RECV,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic take_byte;
        logic next_result;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic last_result;
    } t_stat;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/crsf_frame_receiver.sv */
`timescale 1ns / 1ps
// crsf frame receiver top level: controller plus datapath
// depends on crsf_pkg, crsf_ctrl, crsf_dp
//
// input channel: one serial byte with its millisecond timestamp per item,
// handshaked on i_valid / o_ready. output channel: result items on
// o_valid / i_ready, each carrying kind, channel or link stats fields and
// the good, failed and last-good-time counters as they stand after the frame.
// a byte is taken when i_valid and o_ready are high. bytes that do not end
// a frame give no result and the next byte can be taken on the following
// cycle. the closing byte of a frame is checked against the running crc-8
// in its accept cycle; results then follow in the next cycle: one item, or
// sixteen channel items for an rc channel frame, one per cycle while i_ready
// is high. o_final_res marks the last one. no byte is taken until that last
// result has been handed over, so a stalled receiver simply holds the
// pending result and o_ready stays low. reset (synchronous, active low)
// clears the counters and returns the block to hunting for the sync byte.
module crsf_frame_receiver
    import crsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic [31:0]       i_time_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [3:0]        o_channel_index,
    output logic [10:0]       o_channel_value,
    output logic [7:0]        o_rssi_one,
    output logic [7:0]        o_rssi_two,
    output logic [7:0]        o_link_quality,
    output logic signed [7:0] o_signal_noise,
    output logic [31:0]       o_good_frames,
    output logic [31:0]       o_crc_failures,
    output logic [31:0]       o_last_good_time,
    output logic              o_final_res
);

    t_cmd  cmd;
    t_stat stat;

    crsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    crsf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_rx_byte        (i_rx_byte),
        .i_time_ms        (i_time_ms),
        .o_kind           (o_kind),
        .o_channel_index  (o_channel_index),
        .o_channel_value  (o_channel_value),
        .o_rssi_one       (o_rssi_one),
        .o_rssi_two       (o_rssi_two),
        .o_link_quality   (o_link_quality),
        .o_signal_noise   (o_signal_noise),
        .o_good_frames    (o_good_frames),
        .o_crc_failures   (o_crc_failures),
        .o_last_good_time (o_last_good_time),
        .o_final_res      (o_final_res)
    );

endmodule

/* sv/crsf_ctrl.sv */
`timescale 1ns / 1ps
// controller: alternates between taking bytes and handing out frame results
// depends on crsf_pkg
module crsf_ctrl
    import crsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_ready           = 1'b0;
        o_valid           = 1'b0;
        o_cmd.take_byte   = 1'b0;
        o_cmd.next_result = 1'b0;
        unique case (r_state)
            ST_RECV: begin
                o_ready         = 1'b1;
                o_cmd.take_byte = i_valid;
                if (i_valid && i_stat.frame_done) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                o_valid           = 1'b1;
                o_cmd.next_result = i_ready;
                if (i_ready && i_stat.last_result) begin
                    n_state = ST_RECV;
                end
            end
            default: n_state = ST_RECV;
        endcase
    end

endmodule

/* sv/crsf_dp.sv */
`timescale 1ns / 1ps
// datapath: frame fill count, running crc, captured fields, counters, result fields
// depends on crsf_pkg
module crsf_dp
    import crsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [7:0]            i_rx_byte,
    input  logic [31:0]           i_time_ms,
    output logic [1:0]            o_kind,
    output logic [3:0]            o_channel_index,
    output logic [10:0]           o_channel_value,
    output logic [7:0]            o_rssi_one,
    output logic [7:0]            o_rssi_two,
    output logic [7:0]            o_link_quality,
    output logic signed [7:0]     o_signal_noise,
    output logic [31:0]           o_good_frames,
    output logic [31:0]           o_crc_failures,
    output logic [31:0]           o_last_good_time,
    output logic                  o_final_res
);

    logic [FILL_W-1:0]     r_fill;
    logic [7:0]            r_len;
    logic [7:0]            r_type;
    logic [7:0]            r_crc;
    logic [7:0]            r_link [4];
    logic [RC_BITS-1:0]    r_payload;
    logic [31:0]           r_good;
    logic [31:0]           r_bad;
    logic [31:0]           r_last_time;
    t_kind                 r_kind;
    logic [CHAN_IDX_W-1:0] r_idx;

    logic [7:0] total;
    logic [7:0] fill_next;
    logic       frame_end;
    logic       crc_ok;
    t_kind      good_kind;

    assign total     = r_len + 8'd2;
    assign fill_next = 8'(r_fill) + 8'd1;
    // last byte of a frame arrives when the count reaches the total
    assign frame_end = (r_fill >= FILL_W'(2)) && (r_fill != FILL_W'(MAX_FRAME))
                       && (fill_next == total);
    assign crc_ok    = (i_rx_byte == r_crc);

    always_comb begin
        if (r_type == TYPE_RC_CHANNELS && total == RC_FRAME_LEN) begin
            good_kind = KIND_CHANNEL;
        end else if (r_type == TYPE_LINK_STATS && total >= LINK_MIN_LEN) begin
            good_kind = KIND_LINK;
        end else begin
            good_kind = KIND_OTHER;
        end
    end

    assign o_stat.frame_done  = frame_end;
    assign o_stat.last_result = (r_kind != KIND_CHANNEL)
                                || (r_idx == CHAN_IDX_W'(NUM_CHANNELS - 1));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_last_time <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.take_byte) begin
                if (r_fill == '0) begin
                    if (i_rx_byte == SYNC_BYTE) begin
                        r_fill <= FILL_W'(1);
                    end
                end else if (r_fill == FILL_W'(MAX_FRAME)) begin
                    r_fill <= '0;
                end else if (r_fill == FILL_W'(1)) begin
                    if (i_rx_byte < MIN_LEN || i_rx_byte > MAX_LEN) begin
                        r_fill <= '0;
                    end else begin
                        r_fill <= FILL_W'(2);
                    end
                end else if (frame_end) begin
                    r_fill <= '0;
                    r_idx  <= '0;
                    if (crc_ok) begin
                        r_good      <= r_good + 32'd1;
                        r_last_time <= i_time_ms;
                    end else begin
                        r_bad <= r_bad + 32'd1;
                    end
                end else begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end else if (i_cmd.next_result) begin
                r_idx <= r_idx + CHAN_IDX_W'(1);
            end
        end
    end

    // captured frame fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && r_fill != '0 && r_fill != FILL_W'(MAX_FRAME)) begin
            if (r_fill == FILL_W'(1)) begin
                r_len <= i_rx_byte;
                r_crc <= '0;
            end else begin
                if (r_fill == FILL_W'(2)) begin
                    r_type <= i_rx_byte;
                end
                for (int k = 0; k < 4; k++) begin
                    if (r_fill == FILL_W'(LINK_FIRST + k)) begin
                        r_link[k] <= i_rx_byte;
                    end
                end
                if (r_fill >= FILL_W'(RC_FIRST_BYTE) && r_fill <= FILL_W'(RC_LAST_BYTE)) begin
                    r_payload <= {i_rx_byte, r_payload[RC_BITS-1:8]};
                end
                if (frame_end) begin
                    r_kind <= crc_ok ? good_kind : KIND_BAD_CRC;
                end else begin
                    r_crc <= crc8_update(r_crc, i_rx_byte);
                end
            end
        end else if (i_cmd.next_result) begin
            // channels leave lowest bits first
            r_payload <= {{CHAN_W{1'b0}}, r_payload[RC_BITS-1:CHAN_W]};
        end
    end

    always_comb begin
        o_kind           = r_kind;
        o_channel_index  = '0;
        o_channel_value  = '0;
        o_rssi_one       = '0;
        o_rssi_two       = '0;
        o_link_quality   = '0;
        o_signal_noise   = '0;
        o_good_frames    = r_good;
        o_crc_failures   = r_bad;
        o_last_good_time = r_last_time;
        o_final_res      = o_stat.last_result;
        unique case (r_kind)
            KIND_CHANNEL: begin
                o_channel_index = r_idx;
                o_channel_value = r_payload[CHAN_W-1:0];
            end
            KIND_LINK: begin
                o_rssi_one     = r_link[0];
                o_rssi_two     = r_link[1];
                o_link_quality = r_link[2];
                o_signal_noise = signed'(r_link[3]);
            end
            KIND_BAD_CRC, KIND_OTHER: begin
            end
            default: begin
            end
        endcase
    end

endmodule

/* tb/sv/crsf_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for crsf_frame_receiver: byte stream in, frame results out
// depends on crsf_pkg and the crsf_frame_receiver rtl; stands alone otherwise
module crsf_frame_receiver_tb;
    import crsf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int ITEM_TARGET  = 370;
    localparam int STEADY_FROM  = 300;

    typedef enum logic { ROW_NOISE, ROW_FRAME } t_row_op;
    typedef enum logic [1:0] { FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RAND } t_fill;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  idx;
        logic [10:0] val;
        logic [7:0]  rssi1;
        logic [7:0]  rssi2;
        logic [7:0]  lq;
        logic [7:0]  snr;
        logic [31:0] good;
        logic [31:0] bad;
        logic [31:0] stamp;
        logic        fin;
    } t_rx_result;

    // noise rows send val as one byte, frame rows use val as the length byte
    typedef struct {
        t_row_op     op;
        logic [7:0]  val;
        logic [7:0]  ftype;
        t_fill       fill;
        bit          corrupt;
        logic [31:0] stamp;
        bit          typed;
        t_kind       exp_kind;
        logic [31:0] exp_good;
        logic [31:0] exp_bad;
        logic [31:0] exp_last;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte = 8'h00;
    logic [31:0]        i_time_ms = 32'h0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_kind;
    logic [3:0]         o_channel_index;
    logic [10:0]        o_channel_value;
    logic [7:0]         o_rssi_one;
    logic [7:0]         o_rssi_two;
    logic [7:0]         o_link_quality;
    logic signed [7:0]  o_signal_noise;
    logic [31:0]        o_good_frames;
    logic [31:0]        o_crc_failures;
    logic [31:0]        o_last_good_time;
    logic               o_final_res;

    // predictor state
    logic [7:0]  fstore [MAX_FRAME];
    int          fill = 0;
    logic [31:0] good_cnt = 0;
    logic [31:0] bad_cnt = 0;
    logic [31:0] last_ms = 0;
    t_rx_result  pending_results[$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  bytes_driven = 0;
    int  bytes_taken = 0;
    int  results_checked = 0;
    int  chan_results = 0;
    int  link_results = 0;
    int  stall_left = 0;
    bit  steady = 1'b0;

    t_stim_row directed_rows [0:20] = '{
        '{ROW_NOISE, 8'h00, 8'h00, FILL_ZERO,  1'b0, 32'h0,        1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_NOISE, 8'hFF, 8'h00, FILL_ZERO,  1'b0, 32'hFFFFFFFF, 1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'd4,  8'h2A, FILL_COUNT, 1'b1, 32'h0,        1'b1, KIND_BAD_CRC, 0,  1, 0},
        '{ROW_FRAME, 8'd2,  8'h00, FILL_ZERO,  1'b0, 32'h0,        1'b1, KIND_OTHER,   1,  1, 0},
        '{ROW_FRAME, 8'd0,  8'h00, FILL_ZERO,  1'b0, 32'd50,       1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'd1,  8'h00, FILL_ZERO,  1'b0, 32'd51,       1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'd63, 8'h00, FILL_ZERO,  1'b0, 32'd52,       1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'hFF, 8'h00, FILL_ZERO,  1'b0, 32'd53,       1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'd62, 8'hFF, FILL_ONES,  1'b0, 32'hFFFFFFFF, 1'b1, KIND_OTHER,   2,  1,
          32'hFFFFFFFF},
        '{ROW_FRAME, 8'd24, TYPE_RC_CHANNELS, FILL_ONES, 1'b0, 32'd1000, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd24, TYPE_RC_CHANNELS, FILL_ZERO, 1'b0, 32'd1001, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd24, TYPE_RC_CHANNELS, FILL_RAND, 1'b0, 32'd1002, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd10, TYPE_RC_CHANNELS, FILL_COUNT, 1'b0, 32'd1003, 1'b1, KIND_OTHER, 6, 1,
          32'd1003},
        '{ROW_FRAME, 8'd10, TYPE_LINK_STATS, FILL_ONES, 1'b0, 32'd1004, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd9,  TYPE_LINK_STATS, FILL_COUNT, 1'b0, 32'd1005, 1'b1, KIND_OTHER, 8, 1,
          32'd1005},
        '{ROW_FRAME, 8'd14, TYPE_LINK_STATS, FILL_RAND, 1'b0, 32'd1006, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd24, TYPE_RC_CHANNELS, FILL_RAND, 1'b1, 32'd1007, 1'b1, KIND_BAD_CRC, 9, 2,
          32'd1006},
        '{ROW_FRAME, 8'd3,  SYNC_BYTE, FILL_COUNT, 1'b0, 32'd1008, 1'b1, KIND_OTHER, 10, 2,
          32'd1008},
        '{ROW_NOISE, SYNC_BYTE, 8'h00, FILL_ZERO, 1'b0, 32'd1009, 1'b0, KIND_OTHER, 0, 0, 0},
        '{ROW_FRAME, 8'd2,  8'h00, FILL_ZERO,  1'b0, 32'd1010,     1'b0, KIND_OTHER,   0,  0, 0},
        '{ROW_FRAME, 8'd10, TYPE_LINK_STATS, FILL_COUNT, 1'b0, 32'hFFFFFFFF, 1'b0, KIND_OTHER,
          0, 0, 0}
    };

    crsf_frame_receiver DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    task automatic push_result(input t_rx_result r);
        r.good  = good_cnt;
        r.bad   = bad_cnt;
        r.stamp = last_ms;
        pending_results.push_back(r);
    endtask

    // crc check and result items for a frame whose last byte just arrived
    task automatic close_frame(input int total, input logic [31:0] stamp);
        logic [7:0]         crc;
        logic [RC_BITS-1:0] rc_bits;
        t_rx_result         r;
        crc = 8'h00;
        for (int i = 2; i < total - 1; i++) begin
            crc = crc8_next(crc, fstore[i]);
        end
        r = '0;
        if (fstore[total-1] != crc) begin
            bad_cnt++;
            r.kind = KIND_BAD_CRC;
            r.fin  = 1'b1;
            push_result(r);
        end else begin
            good_cnt++;
            last_ms = stamp;
            if (fstore[2] == TYPE_RC_CHANNELS && total == RC_FRAME_LEN) begin
                for (int i = 0; i <= RC_LAST_BYTE - RC_FIRST_BYTE; i++) begin
                    rc_bits[8*i +: 8] = fstore[RC_FIRST_BYTE + i];
                end
                for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                    r.kind = KIND_CHANNEL;
                    r.idx  = 4'(ch);
                    r.val  = rc_bits[ch*CHAN_W +: CHAN_W];
                    r.fin  = (ch == NUM_CHANNELS - 1);
                    push_result(r);
                end
            end else if (fstore[2] == TYPE_LINK_STATS && total >= LINK_MIN_LEN) begin
                r.kind  = KIND_LINK;
                r.rssi1 = fstore[LINK_FIRST];
                r.rssi2 = fstore[LINK_FIRST + 1];
                r.lq    = fstore[LINK_FIRST + 2];
                r.snr   = fstore[LINK_FIRST + 3];
                r.fin   = 1'b1;
                push_result(r);
            end else begin
                r.kind = KIND_OTHER;
                r.fin  = 1'b1;
                push_result(r);
            end
        end
    endtask

    task automatic track_rx_byte(input logic [7:0] b, input logic [31:0] stamp);
        int total;
        if (fill == 0) begin
            if (b == SYNC_BYTE) begin
                fstore[0] = b;
                fill = 1;
            end
        end else if (fill >= MAX_FRAME) begin
            // overrun, back to hunting
            fill = 0;
        end else begin
            fstore[fill] = b;
            fill++;
            total = int'(fstore[1]) + 2;
            if (fill == 2) begin
                if (b < MIN_LEN || b > MAX_LEN) begin
                    fill = 0;
                end
            end else if (fill >= total) begin
                close_frame(total, stamp);
                fill = 0;
            end
        end
    endtask

    task automatic check_result();
        t_rx_result e;
        if (pending_results.size() == 0) begin
            flag_error($sformatf("result kind %0d with nothing expected", o_kind));
            return;
        end
        e = pending_results.pop_front();
        compare_field("kind", 32'(o_kind), 32'(e.kind));
        compare_field("channel_index", 32'(o_channel_index), 32'(e.idx));
        compare_field("channel_value", 32'(o_channel_value), 32'(e.val));
        compare_field("rssi_one", 32'(o_rssi_one), 32'(e.rssi1));
        compare_field("rssi_two", 32'(o_rssi_two), 32'(e.rssi2));
        compare_field("link_quality", 32'(o_link_quality), 32'(e.lq));
        compare_field("signal_noise", 32'($unsigned(o_signal_noise)), 32'(e.snr));
        compare_field("good_frames", o_good_frames, e.good);
        compare_field("crc_failures", o_crc_failures, e.bad);
        compare_field("last_good_time", o_last_good_time, e.stamp);
        compare_field("final_res", 32'(o_final_res), 32'(e.fin));
        results_checked++;
        if (e.kind == KIND_CHANNEL) chan_results++;
        if (e.kind == KIND_LINK) link_results++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                track_rx_byte(i_rx_byte, i_time_ms);
                bytes_taken++;
            end
            if (o_valid && i_ready) begin
                check_result();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure in bursts of random length, none once steady
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic [31:0] stamp);
        if (!steady && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        i_time_ms <= stamp;
        do @(posedge i_clk); while (!o_ready);
        bytes_driven++;
        @(negedge i_clk);
    endtask

    // sync, length, then type, payload and crc when the length is legal
    task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                              input t_fill fill_mode, input bit corrupt,
                              input logic [31:0] stamp);
        logic [7:0] crc;
        logic [7:0] pb;
        put_byte(SYNC_BYTE, stamp);
        put_byte(len, stamp);
        if (len < MIN_LEN || len > MAX_LEN) return;
        crc = 8'h00;
        for (int i = 0; i < int'(len) - 1; i++) begin
            if (i == 0) begin
                pb = ftype;
            end else begin
                case (fill_mode)
                    FILL_ZERO:  pb = 8'h00;
                    FILL_ONES:  pb = 8'hFF;
                    FILL_COUNT: pb = 8'(i);
                    default:    pb = 8'($urandom);
                endcase
            end
            crc = crc8_next(crc, pb);
            put_byte(pb, stamp);
        end
        if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
        put_byte(crc, stamp);
    endtask

    initial begin
        t_stim_row  row;
        t_rx_result e;
        int         pick;
        int         n;
        logic [7:0] len;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == ROW_NOISE) begin
                put_byte(row.val, row.stamp);
            end else begin
                send_frame(row.val, row.ftype, row.fill, row.corrupt, row.stamp);
            end
            // hand-typed expectation replaces the predicted one for this frame
            if (row.typed && pending_results.size() > 0) begin
                e = pending_results.pop_back();
                e.kind  = row.exp_kind;
                e.good  = row.exp_good;
                e.bad   = row.exp_bad;
                e.stamp = row.exp_last;
                pending_results.push_back(e);
            end
        end

        while (bytes_driven < ITEM_TARGET) begin
            steady = (bytes_driven >= STEADY_FROM);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_frame(RC_FRAME_LEN - 8'd2, TYPE_RC_CHANNELS, FILL_RAND,
                           $urandom_range(0, 9) == 0, $urandom);
            end else if (pick < 48) begin
                send_frame(8'($urandom_range(LINK_MIN_LEN - 2, 14)), TYPE_LINK_STATS,
                           FILL_RAND, $urandom_range(0, 9) == 0, $urandom);
            end else if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(MIN_LEN, MAX_LEN))
                                                  : 8'($urandom_range(MIN_LEN, 16));
                send_frame(len, 8'($urandom_range(0, 255)), FILL_RAND,
                           $urandom_range(0, 7) == 0, $urandom);
            end else if (pick < 78) begin
                send_frame(8'($urandom_range(MIN_LEN, 24)), 8'($urandom_range(0, 255)),
                           FILL_RAND, 1'b1, $urandom);
            end else if (pick < 88) begin
                n = $urandom_range(1, 4);
                repeat (n) put_byte(8'($urandom_range(0, 255)), $urandom);
            end else if (pick < 94) begin
                // illegal length byte
                put_byte(SYNC_BYTE, $urandom);
                len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, MIN_LEN - 1))
                                                  : 8'($urandom_range(MAX_LEN + 1, 255));
                put_byte(len, $urandom);
            end else begin
                // truncated frame, the next frame's bytes get swallowed into it
                len = 8'($urandom_range(4, 24));
                put_byte(SYNC_BYTE, $urandom);
                put_byte(len, $urandom);
                n = $urandom_range(1, len - 1);
                repeat (n) put_byte(8'($urandom_range(0, 255)), $urandom);
            end
        end
        steady = 1'b1;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes taken, %0d good frames, %0d crc failures",
                 bytes_taken, good_cnt, bad_cnt);
        $display("checked %0d result items: %0d rc channel values, %0d link stats",
                 results_checked, chan_results, link_results);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/crsf_pkg.sv
sv/crsf_ctrl.sv
sv/crsf_dp.sv
sv/crsf_frame_receiver.sv
tb/sv/crsf_frame_receiver_tb.sv
